// ===== rtl/ilga_pkg.sv =====
package ilga_pkg;

   localparam int DATA_W     = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_W      = 5;

   // Bit of the byte address that selects the register word.
   localparam int CSR_SEL_BIT = 2;

   // Register word indexes.
   localparam logic REG_MAX_RECTS_USED = 1'b0;

   localparam logic [REG_W-1:0] MAX_RECTS_USED_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_WALK,
      ST_POST,
      ST_HEAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] size;
      logic [DATA_W-1:0] left_hi;
      logic [DATA_W-1:0] right_lo;
   } gap_data_type;

   typedef struct packed {
      logic en;
      logic valid;
   } slot_wr_type;

endpackage

// ===== rtl/ilga_if.sv =====
interface ilga_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ilga_pkg::DATA_W-1:0] entry_lo;
   logic signed [ilga_pkg::DATA_W-1:0] entry_hi;
   logic                                entry_last;

   modport source (output valid, output entry_lo, output entry_hi, output entry_last,
                   input ready);
   modport sink (input valid, input entry_lo, input entry_hi, input entry_last,
                 output ready);
endinterface

interface ilga_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ilga_pkg::DATA_W-1:0] out_lo;
   logic signed [ilga_pkg::DATA_W-1:0] out_hi;
   logic                                out_last;

   modport source (output valid, output out_lo, output out_hi, output out_last,
                   input ready);
   modport sink (input valid, input out_lo, input out_hi, input out_last,
                 output ready);
endinterface

// ===== rtl/ilga_slots.sv =====
// Kept-gap store: one read port and one write port, with a valid bit per slot.
// A slot that is not valid reads as size zero.
module ilga_slots #(
   parameter int SLOTS = 15,
   parameter int POS_W = 16,
   parameter int IDX_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic [IDX_W-1:0]       rd_idx,
   output logic                   rd_valid,
   output ilga_pkg::gap_data_type rd_data,
   output logic [POS_W-1:0]       rd_pos,
   input  ilga_pkg::slot_wr_type  wr_ctl,
   input  logic [IDX_W-1:0]       wr_idx,
   input  ilga_pkg::gap_data_type wr_data,
   input  logic [POS_W-1:0]       wr_pos
);

   localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [SLOTS-1:0]       valid_ff;
   logic [SLOTS-1:0]       valid_in;
   ilga_pkg::gap_data_type data_ff [SLOTS];
   logic [POS_W-1:0]       pos_ff [SLOTS];
   logic                   rd_in_range;
   logic [SIW-1:0]         rd_sel;
   logic [SIW-1:0]         wr_sel;

   assign rd_sel      = rd_idx[SIW-1:0];
   assign wr_sel      = wr_idx[SIW-1:0];
   assign rd_in_range = (32'(rd_idx) < SLOTS);

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_ctl.en) begin
         valid_in[wr_sel] = wr_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.en) begin
         data_ff[wr_sel] <= wr_data;
         pos_ff[wr_sel]  <= wr_pos;
      end
   end

   always_comb begin
      rd_valid = 1'b0;
      rd_data  = '0;
      rd_pos   = '0;
      if (rd_in_range) begin
         rd_valid = valid_ff[rd_sel];
         rd_pos   = pos_ff[rd_sel];
         if (valid_ff[rd_sel]) begin
            rd_data = data_ff[rd_sel];
         end
      end
   end

endmodule

// ===== rtl/interval_list_gap_approximation.sv =====
// Channel   Dir  Handshake      Payload
// req_chan  in   valid/ready    entry_lo, entry_hi, entry_last
// rsp_chan  out  valid/ready    out_lo, out_hi, out_last
// csr_*     in   APB write/read max_rects_used at byte address 0
//
// A non-final interval that opens the list only records its bounds; any other one has its gap
// walked up the k = M-1 slots, one per cycle by the insertion sequencer, while the gap is larger.
// A final interval then emits results from the stored heads if the list has at most M entries;
// otherwise each result follows a scan over the k slots of the slot store.
// Reset is synchronous; no clearing pass is needed, slot valid bits clear at once.
// A waiting result never blocks intake of the next interval until a new result is due.
module interval_list_gap_approximation #(
   parameter int MAX_RECTS   = 16,
   parameter int MAX_ENTRIES = 65535
) (
   input  logic                               clock,
   input  logic                               reset,
   ilga_req_if.sink                           req_chan,
   ilga_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ilga_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ilga_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ilga_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int SLOTS = MAX_RECTS - 1;
   localparam int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int HW    = $clog2(MAX_RECTS);
   localparam int NW    = $clog2(MAX_ENTRIES + 1);
   localparam int DW    = ilga_pkg::DATA_W;

   ilga_pkg::state_type state_ff, state_in;

   logic [ilga_pkg::REG_W-1:0] max_rects_ff;
   logic                       csr_write;

   logic [DW-1:0]    head_lo_ff [MAX_RECTS];
   logic [DW-1:0]    head_hi_ff [MAX_RECTS];
   logic             head_we;

   logic [DW-1:0]    first_lo_ff, first_lo_in;
   logic [DW-1:0]    prev_hi_ff, prev_hi_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             last_ff, last_in;
   logic [DW-1:0]    gap_ff, gap_in;
   logic [NW-1:0]    pos_ff, pos_in;
   logic [DW-1:0]    lhi_ff, lhi_in;
   logic [DW-1:0]    rlo_ff, rlo_in;
   logic [CW-1:0]    j_ff, j_in;
   logic [HW-1:0]    o_ff, o_in;
   logic [SLOTS-1:0] em_ff, em_in;
   logic             found_ff, found_in;
   logic [SIW-1:0]   best_ff, best_in;
   logic [NW-1:0]    best_pos_ff, best_pos_in;
   logic [DW-1:0]    best_rlo_ff, best_rlo_in;
   logic [DW-1:0]    best_lhi_ff, best_lhi_in;
   logic [DW-1:0]    cur_lo_ff, cur_lo_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]    rsp_lo_ff, rsp_lo_in;
   logic [DW-1:0]    rsp_hi_ff, rsp_hi_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [CW-1:0]          k;
   logic                   list_short;
   logic                   accept;
   logic                   out_free;
   logic [DW:0]            diff;
   logic [CW-1:0]          nxt;
   logic                   cand_less;
   logic                   clear_list;

   logic [CW-1:0]          rd_idx;
   logic                   rd_valid;
   ilga_pkg::gap_data_type rd_data;
   logic [NW-1:0]          rd_pos;
   ilga_pkg::slot_wr_type  wr_ctl;
   ilga_pkg::gap_data_type wr_data;
   logic [NW-1:0]          wr_pos;

   ilga_slots #(
      .SLOTS (SLOTS),
      .POS_W (NW),
      .IDX_W (CW)
   ) u_slots (
      .clock    (clock),
      .reset    (reset),
      .clear    (clear_list),
      .rd_idx   (rd_idx),
      .rd_valid (rd_valid),
      .rd_data  (rd_data),
      .rd_pos   (rd_pos),
      .wr_ctl   (wr_ctl),
      .wr_idx   (j_ff),
      .wr_data  (wr_data),
      .wr_pos   (wr_pos)
   );

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[ilga_pkg::CSR_SEL_BIT] == ilga_pkg::REG_MAX_RECTS_USED);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[ilga_pkg::CSR_SEL_BIT] == ilga_pkg::REG_MAX_RECTS_USED) begin
         csr_prdata = {{(ilga_pkg::CSR_DATA_W-ilga_pkg::REG_W){1'b0}}, max_rects_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rects_ff <= ilga_pkg::MAX_RECTS_USED_RESET;
      end else if (csr_write) begin
         max_rects_ff <= csr_pwdata[ilga_pkg::REG_W-1:0];
      end
   end

   // Number of usable slots, one less than the clamped interval limit.
   always_comb begin
      if (max_rects_ff < 5'd2) begin
         k = CW'(1);
      end else if (32'(max_rects_ff) > MAX_RECTS) begin
         k = CW'(SLOTS);
      end else begin
         k = CW'(max_rects_ff - 5'd1);
      end
   end

   assign list_short = (32'(count_ff) <= 32'(k) + 32'd1);

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign diff     = {req_chan.entry_lo[DW-1], req_chan.entry_lo} -
                     {prev_hi_ff[DW-1], prev_hi_ff};
   assign nxt      = j_ff + CW'(1);

   // Position order: position, then right bound, then left bound (both signed).
   assign cand_less = (rd_pos < best_pos_ff) ||
                      ((rd_pos == best_pos_ff) &&
                       (($signed(rd_data.right_lo) < $signed(best_rlo_ff)) ||
                        ((rd_data.right_lo == best_rlo_ff) &&
                         ($signed(rd_data.left_hi) < $signed(best_lhi_ff)))));

   always_comb begin
      state_in     = state_ff;
      first_lo_in  = first_lo_ff;
      prev_hi_in   = prev_hi_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      gap_in       = gap_ff;
      pos_in       = pos_ff;
      lhi_in       = lhi_ff;
      rlo_in       = rlo_ff;
      j_in         = j_ff;
      o_in         = o_ff;
      em_in        = em_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_pos_in  = best_pos_ff;
      best_rlo_in  = best_rlo_ff;
      best_lhi_in  = best_lhi_ff;
      cur_lo_in    = cur_lo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_lo_in    = rsp_lo_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_last_in  = rsp_last_ff;
      req_chan.ready = 1'b0;
      head_we      = 1'b0;
      clear_list   = 1'b0;
      rd_idx       = '0;
      wr_ctl       = '0;
      wr_data      = rd_data;
      wr_pos       = rd_pos;

      unique case (state_ff)
         ilga_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (accept) begin
               head_we    = (32'(count_ff) < MAX_RECTS);
               last_in    = req_chan.entry_last;
               prev_hi_in = req_chan.entry_hi;
               if (32'(count_ff) < MAX_ENTRIES) begin
                  count_in = count_ff + NW'(1);
               end
               if (count_ff == '0) begin
                  first_lo_in = req_chan.entry_lo;
                  state_in    = ilga_pkg::ST_POST;
               end else begin
                  // A negative difference counts as an empty gap.
                  gap_in   = diff[DW] ? '0 : diff[DW-1:0];
                  pos_in   = count_ff;
                  lhi_in   = prev_hi_ff;
                  rlo_in   = req_chan.entry_lo;
                  state_in = ilga_pkg::ST_FIRST;
               end
            end
         end

         ilga_pkg::ST_FIRST: begin
            rd_idx = '0;
            j_in   = '0;
            if (gap_ff > rd_data.size) begin
               state_in = ilga_pkg::ST_WALK;
            end else begin
               state_in = ilga_pkg::ST_POST;
            end
         end

         ilga_pkg::ST_WALK: begin
            rd_idx = nxt;
            wr_ctl.en = 1'b1;
            if ((nxt < k) && (gap_ff > rd_data.size)) begin
               // Slide the smaller neighbor down one slot and keep walking.
               wr_ctl.valid = rd_valid;
               j_in         = nxt;
            end else begin
               wr_ctl.valid = 1'b1;
               wr_data      = '{size: gap_ff, left_hi: lhi_ff, right_lo: rlo_ff};
               wr_pos       = pos_ff;
               state_in     = ilga_pkg::ST_POST;
            end
         end

         ilga_pkg::ST_POST: begin
            if (!last_ff) begin
               state_in = ilga_pkg::ST_IDLE;
            end else if (list_short) begin
               o_in     = '0;
               state_in = ilga_pkg::ST_HEAD;
            end else begin
               cur_lo_in = first_lo_ff;
               j_in      = '0;
               found_in  = 1'b0;
               state_in  = ilga_pkg::ST_SCAN;
            end
         end

         ilga_pkg::ST_HEAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_lo_in    = head_lo_ff[o_ff];
               rsp_hi_in    = head_hi_ff[o_ff];
               rsp_last_in  = (32'(o_ff) + 32'd1 == 32'(count_ff));
               if (rsp_last_in) begin
                  clear_list = 1'b1;
                  state_in   = ilga_pkg::ST_IDLE;
               end else begin
                  o_in = o_ff + HW'(1);
               end
            end
         end

         ilga_pkg::ST_SCAN: begin
            rd_idx = j_ff;
            // Strict compare keeps the lowest slot among equal keys.
            if (rd_valid && !em_ff[j_ff[SIW-1:0]] && (!found_ff || cand_less)) begin
               found_in    = 1'b1;
               best_in     = j_ff[SIW-1:0];
               best_pos_in = rd_pos;
               best_rlo_in = rd_data.right_lo;
               best_lhi_in = rd_data.left_hi;
            end
            if (32'(j_ff) + 32'd1 == 32'(k)) begin
               state_in = ilga_pkg::ST_EMIT;
            end else begin
               j_in = nxt;
            end
         end

         ilga_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_lo_in    = cur_lo_ff;
               if (found_ff) begin
                  rsp_hi_in      = best_lhi_ff;
                  rsp_last_in    = 1'b0;
                  em_in[best_ff] = 1'b1;
                  cur_lo_in      = best_rlo_ff;
                  j_in           = '0;
                  found_in       = 1'b0;
                  state_in       = ilga_pkg::ST_SCAN;
               end else begin
                  rsp_hi_in   = prev_hi_ff;
                  rsp_last_in = 1'b1;
                  clear_list  = 1'b1;
                  state_in    = ilga_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ilga_pkg::ST_IDLE;
         end
      endcase

      if (clear_list) begin
         first_lo_in = '0;
         prev_hi_in  = '0;
         count_in    = '0;
         em_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilga_pkg::ST_IDLE;
         first_lo_ff  <= '0;
         prev_hi_ff   <= '0;
         count_ff     <= '0;
         em_ff        <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_lo_ff  <= first_lo_in;
         prev_hi_ff   <= prev_hi_in;
         count_ff     <= count_in;
         em_ff        <= em_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      gap_ff      <= gap_in;
      pos_ff      <= pos_in;
      lhi_ff      <= lhi_in;
      rlo_ff      <= rlo_in;
      j_ff        <= j_in;
      o_ff        <= o_in;
      best_ff     <= best_in;
      best_pos_ff <= best_pos_in;
      best_rlo_ff <= best_rlo_in;
      best_lhi_ff <= best_lhi_in;
      cur_lo_ff   <= cur_lo_in;
      rsp_lo_ff   <= rsp_lo_in;
      rsp_hi_ff   <= rsp_hi_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_lo_ff[HW'(count_ff)] <= req_chan.entry_lo;
         head_hi_ff[HW'(count_ff)] <= req_chan.entry_hi;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_lo   = rsp_lo_ff;
   assign rsp_chan.out_hi   = rsp_hi_ff;
   assign rsp_chan.out_last = rsp_last_ff;

endmodule

// ===== rtl/ilga_check.sv =====
module ilga_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ilga_pkg::DATA_W-1:0]     rsp_lo,
   input logic [ilga_pkg::DATA_W-1:0]     rsp_hi,
   input logic                            rsp_last,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [ilga_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [ilga_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [ilga_pkg::CSR_DATA_W-1:0] csr_prdata
);

   // A result waiting for its transfer holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_lo) && $stable(rsp_hi) && $stable(rsp_last)))
      else $error("result changed while stalled");

   // Every interval needs work after its transfer before the next one is taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken on the cycle after a transfer");

   // A register write is visible on the read data right after it.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite &&
       (csr_paddr[ilga_pkg::CSR_SEL_BIT] == ilga_pkg::REG_MAX_RECTS_USED)) |=>
         ((csr_paddr[ilga_pkg::CSR_SEL_BIT] != ilga_pkg::REG_MAX_RECTS_USED) ||
          (csr_prdata[ilga_pkg::REG_W-1:0] == $past(csr_pwdata[ilga_pkg::REG_W-1:0]))))
      else $error("register read back differs from last write");

   // Reset leaves no result pending.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind interval_list_gap_approximation ilga_check u_ilga_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_lo      (rsp_chan.out_lo),
   .rsp_hi      (rsp_chan.out_hi),
   .rsp_last    (rsp_chan.out_last),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

// ===== verif/interval_list_gap_approximation_tb.sv =====
`timescale 1ns / 100ps

module interval_list_gap_approximation_tb;
   import ilga_pkg::*;

   localparam int RECT_CAP        = 16;
   localparam int ENTRY_CAP       = 65535;
   localparam int SLOTS           = RECT_CAP - 1;
   localparam int RANDOM_TARGET   = 220;
   localparam int DRAIN_CYCLES    = 48;
   localparam int LONG_HOLD       = 300;
   localparam int STALL_LIMIT     = 20000;
   localparam int LONG_BACKGROUND = 65536;
   localparam int ROW_COUNT       = 27;

   localparam logic [31:0] S32_MIN = 32'h8000_0000;
   localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [CSR_ADDR_W-1:0] MAX_RECTS_ADDR =
      CSR_ADDR_W'(REG_MAX_RECTS_USED) << CSR_SEL_BIT;

   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
      logic        last;
   } span_t;

   typedef enum logic {ROW_ENTRY, ROW_SETTING} row_kind_t;

   typedef struct packed {
      row_kind_t   kind;
      logic [31:0] lo;
      logic [31:0] hi;
      logic        last;
      logic        typed;
      logic [31:0] want_lo;
      logic [31:0] want_hi;
      logic        want_last;
   } stim_row_t;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ilga_req_if entry_chan();
   ilga_rsp_if span_chan();

   interval_list_gap_approximation #(
      .MAX_RECTS  (RECT_CAP),
      .MAX_ENTRIES(ENTRY_CAP)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (entry_chan),
      .rsp_chan   (span_chan),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Shadow copy of the block's list state.
   logic [4:0]  max_rects_reg;
   logic [31:0] head_lo [RECT_CAP];
   logic [31:0] head_hi [RECT_CAP];
   logic [31:0] gap_size [SLOTS];
   int unsigned gap_pos [SLOTS];
   logic [31:0] gap_left_hi [SLOTS];
   logic [31:0] gap_right_lo [SLOTS];
   logic        gap_valid [SLOTS];
   logic [31:0] list_first_lo;
   logic [31:0] list_prev_hi;
   int unsigned list_count;

   span_t fresh_spans[$];
   span_t expected_spans[$];
   span_t span_want;

   int  mismatch_count;
   int  spans_checked;
   int  entries_sent;
   int  lists_sent;
   int  random_entries;
   int  settings_used;
   int  quiet_cycles;
   bit  idle_enable;
   bit  rsp_hold_request;
   stim_row_t directed_rows [ROW_COUNT];

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic span_t span_of(input logic [31:0] lo, hi, input logic last);
      span_t s;
      s.lo = lo;
      s.hi = hi;
      s.last = last;
      return s;
   endfunction

   function automatic int unsigned rects_in_use();
      if (max_rects_reg < 2) return 2;
      if (max_rects_reg > RECT_CAP) return RECT_CAP;
      return max_rects_reg;
   endfunction

   function automatic void clear_list_state();
      for (int i = 0; i < SLOTS; i++) begin
         gap_size[i] = '0;
         gap_pos[i] = 0;
         gap_left_hi[i] = '0;
         gap_right_lo[i] = '0;
         gap_valid[i] = 1'b0;
      end
      list_first_lo = '0;
      list_prev_hi = '0;
      list_count = 0;
   endfunction

   // Equal positions only happen once the entry count has saturated.
   function automatic bit gap_precedes(input int a, input int b);
      if (gap_pos[a] != gap_pos[b]) return gap_pos[a] < gap_pos[b];
      if (gap_right_lo[a] != gap_right_lo[b])
         return $signed(gap_right_lo[a]) < $signed(gap_right_lo[b]);
      return $signed(gap_left_hi[a]) < $signed(gap_left_hi[b]);
   endfunction

   function automatic void keep_gap(input logic [31:0] size, input int unsigned pos,
                                    input logic [31:0] lhi, rlo, input int unsigned k);
      int unsigned j;
      j = 0;
      if (size <= gap_size[0]) return;
      while (j + 1 < k && size > gap_size[j+1]) begin
         gap_size[j] = gap_size[j+1];
         gap_pos[j] = gap_pos[j+1];
         gap_left_hi[j] = gap_left_hi[j+1];
         gap_right_lo[j] = gap_right_lo[j+1];
         gap_valid[j] = gap_valid[j+1];
         j++;
      end
      gap_size[j] = size;
      gap_pos[j] = pos;
      gap_left_hi[j] = lhi;
      gap_right_lo[j] = rlo;
      gap_valid[j] = 1'b1;
   endfunction

   // Folds one interval into the shadow state and leaves any spans it
   // produces in fresh_spans.
   function automatic void absorb_entry(input span_t e);
      int unsigned m, k, idx;
      int cnt, j;
      int order [SLOTS];
      logic signed [32:0] diff;
      logic [31:0] size;
      logic [31:0] cur_lo;
      m = rects_in_use();
      k = m - 1;
      idx = list_count;
      fresh_spans.delete();
      if (idx < RECT_CAP) begin
         head_lo[idx] = e.lo;
         head_hi[idx] = e.hi;
      end
      if (idx == 0) begin
         list_first_lo = e.lo;
      end else begin
         diff = $signed({e.lo[31], e.lo}) - $signed({list_prev_hi[31], list_prev_hi});
         size = (diff < 0) ? 32'd0 : diff[31:0];
         keep_gap(size, idx, list_prev_hi, e.lo, k);
      end
      list_prev_hi = e.hi;
      if (list_count < ENTRY_CAP) list_count++;
      if (!e.last) return;
      if (list_count <= m) begin
         for (int i = 0; i < list_count; i++)
            fresh_spans.push_back(span_of(head_lo[i], head_hi[i], i + 1 == list_count));
      end else begin
         cnt = 0;
         for (int i = 0; i < k; i++) begin
            if (!gap_valid[i]) continue;
            j = cnt;
            while (j > 0 && gap_precedes(i, order[j-1])) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = i;
            cnt++;
         end
         cur_lo = list_first_lo;
         for (int i = 0; i < cnt; i++) begin
            fresh_spans.push_back(span_of(cur_lo, gap_left_hi[order[i]], 1'b0));
            cur_lo = gap_right_lo[order[i]];
         end
         fresh_spans.push_back(span_of(cur_lo, list_prev_hi, 1'b1));
      end
      clear_list_state();
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("%0t MISMATCH: %s", $realtime, msg);
   endtask

   function automatic int pause_length();
      int roll;
      if (!idle_enable) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one interval and returns at the edge of its transfer. A row with
   // a typed result replaces the shadow's spans with that result.
   task automatic send_entry(input span_t e, input bit typed, input span_t typed_span);
      int pause;
      pause = pause_length();
      @(negedge clock);
      if (pause > 0) begin
         entry_chan.valid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      entry_chan.valid <= 1'b1;
      entry_chan.entry_lo <= e.lo;
      entry_chan.entry_hi <= e.hi;
      entry_chan.entry_last <= e.last;
      @(posedge clock);
      while (!entry_chan.ready) @(posedge clock);
      absorb_entry(e);
      if (typed) begin
         expected_spans.push_back(typed_span);
      end else begin
         foreach (fresh_spans[i]) expected_spans.push_back(fresh_spans[i]);
      end
      entries_sent++;
      if (e.last) lists_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      entry_chan.valid <= 1'b0;
      while (expected_spans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_max_rects(input logic [31:0] value);
      logic [31:0] got;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= MAX_RECTS_ADDR;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      max_rects_reg = value[4:0];
      settings_used++;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== {27'd0, max_rects_reg})
         note_mismatch($sformatf("max_rects_used reads %0d, wrote %0d", got, max_rects_reg));
   endtask

   // Mostly ascending intervals with random steps; a noisy list mixes in
   // intervals drawn from the whole range.
   task automatic send_random_list(input int len, input bit noisy);
      logic signed [63:0] cursor;
      logic signed [63:0] step;
      logic signed [63:0] lo64;
      logic signed [63:0] hi64;
      logic [31:0] seed_word;
      span_t e;
      seed_word = $urandom;
      cursor = {{32{seed_word[31]}}, seed_word};
      for (int i = 0; i < len; i++) begin
         if (noisy && $urandom_range(0, 3) == 0) begin
            e = span_of($urandom, $urandom, i == len - 1);
         end else begin
            case ($urandom_range(0, 9))
               0: step = 0;
               1: begin
                  step = $urandom_range(1, 60);
                  step = -step;
               end
               2, 3, 4: step = $urandom_range(1, 20);
               5, 6: step = $urandom_range(0, 1 << 20);
               7: step = $urandom_range(0, 1 << 30);
               default: step = $urandom_range(1, 4);
            endcase
            lo64 = cursor + step;
            hi64 = lo64 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 1 << 16)
                                                         : $urandom_range(0, 10));
            e = span_of(lo64[31:0], hi64[31:0], i == len - 1);
            cursor = hi64;
         end
         send_entry(e, 1'b0, span_of('0, '0, 1'b0));
         random_entries++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && span_chan.valid && span_chan.ready) begin
         spans_checked++;
         if (expected_spans.size() == 0) begin
            note_mismatch($sformatf("span [%0d, %0d] last=%0b with none pending",
                                    $signed(span_chan.out_lo), $signed(span_chan.out_hi),
                                    span_chan.out_last));
         end else begin
            span_want = expected_spans.pop_front();
            if (span_chan.out_lo !== span_want.lo)
               note_mismatch($sformatf("out_lo %0d, predicted %0d",
                                       $signed(span_chan.out_lo), $signed(span_want.lo)));
            if (span_chan.out_hi !== span_want.hi)
               note_mismatch($sformatf("out_hi %0d, predicted %0d",
                                       $signed(span_chan.out_hi), $signed(span_want.hi)));
            if (span_chan.out_last !== span_want.last)
               note_mismatch($sformatf("out_last %0b, predicted %0b",
                                       span_chan.out_last, span_want.last));
         end
      end
   end

   // Ends the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (entry_chan.valid && entry_chan.ready) ||
          (span_chan.valid && span_chan.ready) || (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d spans outstanding",
                  quiet_cycles, expected_spans.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      span_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0) begin
            stall_left = pause_length();
         end
         if (stall_left > 0) begin
            span_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            span_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      stim_row_t row;
      int phase;
      int len;
      int m;
      int setting_walk [8];

      reset = 1'b1;
      entry_chan.valid = 1'b0;
      entry_chan.entry_lo = '0;
      entry_chan.entry_hi = '0;
      entry_chan.entry_last = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatch_count = 0;
      spans_checked = 0;
      entries_sent = 0;
      lists_sent = 0;
      random_entries = 0;
      settings_used = 0;
      quiet_cycles = 0;
      idle_enable = 1'b1;
      rsp_hold_request = 1'b0;
      max_rects_reg = MAX_RECTS_USED_RESET;
      clear_list_state();
      setting_walk = '{17, 0, 2, 31, 1, 3, 16, 5};

      directed_rows = '{
         // Single-interval lists come back unchanged.
         '{ROW_ENTRY, S32_MIN, S32_MAX, 1'b1, 1'b1, S32_MIN, S32_MAX, 1'b1},
         '{ROW_ENTRY, 32'd0, 32'd0, 1'b1, 1'b1, 32'd0, 32'd0, 1'b1},
         '{ROW_ENTRY, S32_MAX, S32_MIN, 1'b1, 1'b1, S32_MAX, S32_MIN, 1'b1},
         '{ROW_ENTRY, -32'sd10, -32'sd5, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, 32'd0, 32'd4, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, 32'd100, 32'd200, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_SETTING, 32'd3, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         // The widest possible gaps, from the bottom to the top of the range.
         '{ROW_ENTRY, S32_MIN, S32_MIN, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, -32'sd20, -32'sd10, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, 32'd0, 32'd5, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, S32_MAX, S32_MAX, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0},
         // Overlaps give negative gaps, so one slot stays empty.
         '{ROW_ENTRY, 32'd0, 32'd100, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, 32'd50, 32'd60, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, 32'd200, 32'd300, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, 32'd250, 32'd400, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_SETTING, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         // Equal gaps: the later one is not larger, so it is dropped.
         '{ROW_ENTRY, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, 32'd10, 32'd10, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, 32'd20, 32'd20, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_SETTING, 32'd31, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, -32'sd1, -32'sd1, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, 32'd1, 32'd1, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_SETTING, 32'd1, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, 32'd5, 32'd6, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, -32'sd100, -32'sd90, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_ENTRY, 32'd7, 32'd8, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0},
         '{ROW_SETTING, 32'd16, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_SETTING) begin
            wait_idle();
            program_max_rects(row.lo);
         end else begin
            send_entry(span_of(row.lo, row.hi, row.last), row.typed,
                       span_of(row.want_lo, row.want_hi, row.want_last));
         end
      end

      phase = 0;
      while (random_entries < RANDOM_TARGET) begin
         wait_idle();
         program_max_rects((phase < 8) ? setting_walk[phase] : $urandom_range(0, 31));
         idle_enable = (phase % 3 != 2);
         // Short lists while the result side is held off fill the block up.
         if (phase == 1) rsp_hold_request = 1'b1;
         for (int n = 0; n < 4; n++) begin
            m = rects_in_use();
            if (phase == 1) len = $urandom_range(1, 3);
            else if ($urandom_range(0, 3) == 0) len = $urandom_range(m + 1, 20);
            else len = $urandom_range(1, m + 2);
            send_random_list(len, $urandom_range(0, 4) == 0);
         end
         phase++;
      end

      // A list long enough to saturate the entry count, so the last kept
      // gaps share one position and fall back to the bound ordering.
      wait_idle();
      program_max_rects(32'd4);
      idle_enable = 1'b0;
      for (int n = 0; n < LONG_BACKGROUND; n++)
         send_entry(span_of(32'd0, 32'd0, 1'b0), 1'b0, span_of('0, '0, 1'b0));
      send_entry(span_of(32'd0, -32'sd100, 1'b0), 1'b0, span_of('0, '0, 1'b0));
      send_entry(span_of(32'd500, -32'sd300, 1'b0), 1'b0, span_of('0, '0, 1'b0));
      send_entry(span_of(32'd500, -32'sd300, 1'b0), 1'b0, span_of('0, '0, 1'b0));
      send_entry(span_of(32'd400, 32'd50, 1'b1), 1'b0, span_of('0, '0, 1'b0));
      wait_idle();

      $display("Covered %0d intervals in %0d lists (%0d random), %0d spans checked,",
               entries_sent, lists_sent, random_entries, spans_checked);
      $display("%0d register settings, one list past the entry count limit.", settings_used);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== interval_list_gap_approximation.f =====
rtl/ilga_pkg.sv
rtl/ilga_if.sv
rtl/ilga_slots.sv
rtl/interval_list_gap_approximation.sv
rtl/ilga_check.sv
verif/interval_list_gap_approximation_tb.sv
